[hw/rtl/differential_steering_pd_sync_core_assert.svh]
// ----------------------------------------------------------------------------
// differential steering pd sync assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_STEERING_PD_SYNC_CORE_ASSERT_SVH
`define DIFFERENTIAL_STEERING_PD_SYNC_CORE_ASSERT_SVH

// same-cycle implication
`define DSPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dspd assertion failed");

// next-cycle implication
`define DSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dspd assertion failed");

`endif

[hw/rtl/dspd_pkg.sv]
// ----------------------------------------------------------------------------
// dspd_pkg
// types and constants shared by the steering correction core
// ----------------------------------------------------------------------------
package dspd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int POS_W      = 24;
    localparam int LEFT_W     = 26;
    localparam int FACT_W     = 9;
    localparam int PROD_W     = LEFT_W + FACT_W;
    localparam int SPEED_W    = 8;
    localparam int BASE_W     = 8;
    localparam int GAIN_W     = 16;
    localparam int ERR_W      = 32;
    localparam int MUL_W      = ERR_W + 1 + GAIN_W + 1;
    localparam int NUM_W      = MUL_W + 2;
    localparam int STEER_W    = 8;
    localparam int SAT_W      = 10;
    localparam int FRAC_BITS  = 8;

    localparam int STEER_SCALE = 50;

    // x / 50 is ((x >> 1) * ceil(2^36 / 25)) >> 36, exact for x below 2^33
    localparam int               DIV_W       = 32;
    localparam int               RECIP_SHIFT = 36;
    localparam logic [DIV_W-1:0] RECIP_MUL   = 32'd2748779070;

    localparam int SAT_LIMIT  = 300;
    localparam int FOLD_LIMIT = 100;
    localparam int FOLD_STEP  = 200;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_B      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_C      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_B       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_C       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_STEERING = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_B_IS_MAIN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd7;

    typedef struct packed {
        logic signed [POS_W-1:0]  target_b;
        logic signed [POS_W-1:0]  target_c;
        logic signed [POS_W-1:0]  start_b;
        logic signed [POS_W-1:0]  start_c;
        logic signed [BASE_W-1:0] base_steering;
        logic                     b_is_main;
        logic [GAIN_W-1:0]        gain_p;
        logic [GAIN_W-1:0]        gain_d;
    } cfg_t;

    typedef struct packed {
        logic signed [PROD_W-1:0]  prod;
        logic signed [LEFT_W-1:0]  other;
        logic                      b_main;
        logic signed [SPEED_W-1:0] speed;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ERR,
        ST_DIFF,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } back_state_t;

endpackage

[hw/rtl/dspd_front.sv]
// ----------------------------------------------------------------------------
// dspd_front
// takes a transaction, forms remaining travel and scales the main wheel
// ----------------------------------------------------------------------------
module dspd_front (
    input  dspd_pkg::cfg_t                          cfg,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [dspd_pkg::POS_W-1:0]       position_b,
    input  logic signed [dspd_pkg::POS_W-1:0]       position_c,
    input  logic signed [dspd_pkg::SPEED_W-1:0]     speed_in,
    input  logic                                    q_full,
    output logic                                    q_push,
    output dspd_pkg::job_t                          q_data
);

    logic signed [dspd_pkg::LEFT_W-1:0] left_b;
    logic signed [dspd_pkg::LEFT_W-1:0] left_c;
    logic signed [dspd_pkg::LEFT_W-1:0] main_left;
    logic signed [dspd_pkg::FACT_W-1:0] factor;
    logic signed [dspd_pkg::FACT_W-1:0] base_ext;
    logic signed [dspd_pkg::PROD_W-1:0] prod;

    assign left_b = dspd_pkg::LEFT_W'(cfg.target_b) - dspd_pkg::LEFT_W'(position_b)
                  + dspd_pkg::LEFT_W'(cfg.start_b);
    assign left_c = dspd_pkg::LEFT_W'(cfg.target_c) - dspd_pkg::LEFT_W'(position_c)
                  + dspd_pkg::LEFT_W'(cfg.start_c);

    assign base_ext = dspd_pkg::FACT_W'(cfg.base_steering);

    always_comb
    begin
        if (cfg.b_is_main)
        begin
            main_left = left_b;
            factor    = dspd_pkg::FACT_W'(dspd_pkg::STEER_SCALE) - base_ext;
        end
        else
        begin
            main_left = left_c;
            factor    = dspd_pkg::FACT_W'(dspd_pkg::STEER_SCALE) + base_ext;
        end
    end

    assign prod = main_left * factor;

    assign in_stall      = q_full;
    assign q_push        = in_valid && !q_full;
    assign q_data.prod   = prod;
    assign q_data.other  = cfg.b_is_main ? left_c : left_b;
    assign q_data.b_main = cfg.b_is_main;
    assign q_data.speed  = speed_in;

endmodule

[hw/rtl/dspd_fifo.sv]
// ----------------------------------------------------------------------------
// dspd_fifo
// short job queue between the front and the back sequencer
// ----------------------------------------------------------------------------
module dspd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dspd_pkg::job_t  push_data,
    output logic            full,
    input  logic            pop,
    output dspd_pkg::job_t  pop_data,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dspd_pkg::job_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/dspd_back.sv]
// ----------------------------------------------------------------------------
// dspd_back
// divides by fifty, forms the error and pd term, saturates and folds
// ----------------------------------------------------------------------------
module dspd_back (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  dspd_pkg::cfg_t                          cfg,
    input  logic                                    q_empty,
    input  dspd_pkg::job_t                          q_data,
    output logic                                    q_pop,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [dspd_pkg::STEER_W-1:0]     steering_out,
    output logic signed [dspd_pkg::SPEED_W-1:0]     speed_out
);

    localparam int DIV_W  = dspd_pkg::DIV_W;
    localparam int PROD_W = dspd_pkg::PROD_W;
    localparam int ERR_W  = dspd_pkg::ERR_W;
    localparam int MUL_W  = dspd_pkg::MUL_W;
    localparam int NUM_W  = dspd_pkg::NUM_W;
    localparam int SAT_W  = dspd_pkg::SAT_W;

    dspd_pkg::back_state_t state_reg;
    dspd_pkg::back_state_t state_next;

    logic [DIV_W-1:0]                       div_reg;
    logic [DIV_W-1:0]                       div_next;
    logic                                   neg_reg;
    logic                                   neg_next;
    logic signed [dspd_pkg::LEFT_W-1:0]     other_reg;
    logic signed [dspd_pkg::LEFT_W-1:0]     other_next;
    logic                                   bmain_reg;
    logic                                   bmain_next;
    logic signed [dspd_pkg::SPEED_W-1:0]    speed_reg;
    logic signed [dspd_pkg::SPEED_W-1:0]    speed_next;
    logic signed [ERR_W-1:0]                error_reg;
    logic signed [ERR_W-1:0]                error_next;
    logic signed [ERR_W-1:0]                prev_reg;
    logic signed [ERR_W-1:0]                prev_next;
    logic signed [ERR_W:0]                  diff_reg;
    logic signed [ERR_W:0]                  diff_next;
    logic signed [MUL_W-1:0]                prodp_reg;
    logic signed [MUL_W-1:0]                prodp_next;
    logic signed [MUL_W-1:0]                prodd_reg;
    logic signed [MUL_W-1:0]                prodd_next;
    logic signed [NUM_W-1:0]                num_reg;
    logic signed [NUM_W-1:0]                num_next;
    logic signed [dspd_pkg::STEER_W-1:0]    steer_reg;
    logic signed [dspd_pkg::STEER_W-1:0]    steer_next;
    logic signed [dspd_pkg::SPEED_W-1:0]    speedo_reg;
    logic signed [dspd_pkg::SPEED_W-1:0]    speedo_next;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;

    logic [2*DIV_W-1:0]                     recip_w;
    logic [PROD_W-1:0]                      mag;
    logic signed [ERR_W-1:0]                q_s;
    logic signed [dspd_pkg::GAIN_W:0]       gain_p_s;
    logic signed [dspd_pkg::GAIN_W:0]       gain_d_s;
    logic signed [MUL_W:0]                  pd;
    logic signed [NUM_W-1:0]                base_sh;
    logic signed [NUM_W-1:0]                num_adj;
    logic signed [NUM_W-1:0]                quo_s;
    logic signed [SAT_W-1:0]                sat_w;

    // halved magnitude times the reciprocal of twenty-five
    assign recip_w = div_reg * dspd_pkg::RECIP_MUL;

    assign mag = q_data.prod[PROD_W-1] ? PROD_W'(-q_data.prod) : PROD_W'(q_data.prod);

    assign q_s      = neg_reg ? -$signed(div_reg[ERR_W-1:0]) : $signed(div_reg[ERR_W-1:0]);
    assign gain_p_s = $signed({1'b0, cfg.gain_p});
    assign gain_d_s = $signed({1'b0, cfg.gain_d});
    assign pd       = (MUL_W + 1)'(prodp_reg) + (MUL_W + 1)'(prodd_reg);
    assign base_sh  = NUM_W'(cfg.base_steering) <<< dspd_pkg::FRAC_BITS;

    // truncate toward zero, then clamp
    always_comb
    begin
        num_adj = num_reg[NUM_W-1] ? num_reg + NUM_W'((1 << dspd_pkg::FRAC_BITS) - 1)
                                   : num_reg;
        quo_s   = num_adj >>> dspd_pkg::FRAC_BITS;
        if (quo_s > dspd_pkg::SAT_LIMIT)
        begin
            sat_w = SAT_W'(dspd_pkg::SAT_LIMIT);
        end
        else if (quo_s < -dspd_pkg::SAT_LIMIT)
        begin
            sat_w = SAT_W'(-dspd_pkg::SAT_LIMIT);
        end
        else
        begin
            sat_w = SAT_W'(quo_s);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        div_next       = div_reg;
        neg_next       = neg_reg;
        other_next     = other_reg;
        bmain_next     = bmain_reg;
        speed_next     = speed_reg;
        error_next     = error_reg;
        prev_next      = prev_reg;
        diff_next      = diff_reg;
        prodp_next     = prodp_reg;
        prodd_next     = prodd_reg;
        num_next       = num_reg;
        steer_next     = steer_reg;
        speedo_next    = speedo_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;

        case (state_reg)
            dspd_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    div_next   = mag[DIV_W:1];
                    neg_next   = q_data.prod[PROD_W-1];
                    other_next = q_data.other;
                    bmain_next = q_data.b_main;
                    speed_next = q_data.speed;
                    state_next = dspd_pkg::ST_DIV;
                end
            end
            dspd_pkg::ST_DIV:
            begin
                div_next   = DIV_W'(recip_w >> dspd_pkg::RECIP_SHIFT);
                state_next = dspd_pkg::ST_ERR;
            end
            dspd_pkg::ST_ERR:
            begin
                if (bmain_reg)
                begin
                    error_next = q_s - ERR_W'(other_reg);
                end
                else
                begin
                    error_next = ERR_W'(other_reg) - q_s;
                end
                state_next = dspd_pkg::ST_DIFF;
            end
            dspd_pkg::ST_DIFF:
            begin
                diff_next  = (ERR_W + 1)'(error_reg) - (ERR_W + 1)'(prev_reg);
                prev_next  = error_reg;
                state_next = dspd_pkg::ST_MUL;
            end
            dspd_pkg::ST_MUL:
            begin
                prodp_next = error_reg * gain_p_s;
                prodd_next = diff_reg * gain_d_s;
                state_next = dspd_pkg::ST_ADD;
            end
            dspd_pkg::ST_ADD:
            begin
                if (speed_reg > 0)
                begin
                    num_next = base_sh + NUM_W'(pd);
                end
                else
                begin
                    num_next = base_sh - NUM_W'(pd);
                end
                state_next = dspd_pkg::ST_OUT;
            end
            dspd_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    if (sat_w > dspd_pkg::FOLD_LIMIT)
                    begin
                        steer_next  = dspd_pkg::STEER_W'(sat_w - SAT_W'(dspd_pkg::FOLD_STEP));
                        speedo_next = -speed_reg;
                    end
                    else if (sat_w < -dspd_pkg::FOLD_LIMIT)
                    begin
                        steer_next  = dspd_pkg::STEER_W'(sat_w + SAT_W'(dspd_pkg::FOLD_STEP));
                        speedo_next = -speed_reg;
                    end
                    else
                    begin
                        steer_next  = dspd_pkg::STEER_W'(sat_w);
                        speedo_next = speed_reg;
                    end
                    out_valid_next = 1'b1;
                    state_next     = dspd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dspd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dspd_pkg::ST_IDLE;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg    <= div_next;
        neg_reg    <= neg_next;
        other_reg  <= other_next;
        bmain_reg  <= bmain_next;
        speed_reg  <= speed_next;
        error_reg  <= error_next;
        diff_reg   <= diff_next;
        prodp_reg  <= prodp_next;
        prodd_reg  <= prodd_next;
        num_reg    <= num_next;
        steer_reg  <= steer_next;
        speedo_reg <= speedo_next;
    end

    assign out_valid    = out_valid_reg;
    assign steering_out = steer_reg;
    assign speed_out    = speedo_reg;

endmodule

[hw/rtl/differential_steering_pd_sync_core.sv]
// ----------------------------------------------------------------------------
// differential_steering_pd_sync_core
// pd steering correction that keeps two driven wheels in step
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  in        in_valid/in_stall   position_b, position_c, speed_in
//  out       out_valid/out_stall steering_out, speed_out
//  cfg       cfg_valid/cfg_ready cfg_index, cfg_data
//
//  the back sequencer takes each transaction from the queue, divides by fifty
//  as a reciprocal multiply, then forms error, difference, multiply, add and
//  fold, each in its own state; the fold state waits while a stalled result is held
//  reset clears the queue, the sequencer and the previous error and resets the config registers
//  in_stall rises while the job queue is full; a stalled result holds in the
//  output register while the next job is already being worked on
// ----------------------------------------------------------------------------
module differential_steering_pd_sync_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_stall,
    input  logic signed [dspd_pkg::POS_W-1:0]           position_b,
    input  logic signed [dspd_pkg::POS_W-1:0]           position_c,
    input  logic signed [dspd_pkg::SPEED_W-1:0]         speed_in,
    output logic                                        out_valid,
    input  logic                                        out_stall,
    output logic signed [dspd_pkg::STEER_W-1:0]         steering_out,
    output logic signed [dspd_pkg::SPEED_W-1:0]         speed_out,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [dspd_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  logic [dspd_pkg::CFG_DATA_W-1:0]             cfg_data
);

    dspd_pkg::cfg_t                         cfg;
    logic signed [dspd_pkg::POS_W-1:0]      target_b_reg;
    logic signed [dspd_pkg::POS_W-1:0]      target_c_reg;
    logic signed [dspd_pkg::POS_W-1:0]      start_b_reg;
    logic signed [dspd_pkg::POS_W-1:0]      start_c_reg;
    logic signed [dspd_pkg::BASE_W-1:0]     base_reg;
    logic                                   b_is_main_reg;
    logic [dspd_pkg::GAIN_W-1:0]            gain_p_reg;
    logic [dspd_pkg::GAIN_W-1:0]            gain_d_reg;

    logic                                   q_push;
    logic                                   q_pop;
    logic                                   q_full;
    logic                                   q_empty;
    dspd_pkg::job_t                         q_in;
    dspd_pkg::job_t                         q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_b_reg  <= '0;
            target_c_reg  <= '0;
            start_b_reg   <= '0;
            start_c_reg   <= '0;
            base_reg      <= '0;
            b_is_main_reg <= 1'b1;
            gain_p_reg    <= dspd_pkg::GAIN_W'(1 << dspd_pkg::FRAC_BITS);
            gain_d_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dspd_pkg::REG_TARGET_B:      target_b_reg  <= cfg_data[dspd_pkg::POS_W-1:0];
                dspd_pkg::REG_TARGET_C:      target_c_reg  <= cfg_data[dspd_pkg::POS_W-1:0];
                dspd_pkg::REG_START_B:       start_b_reg   <= cfg_data[dspd_pkg::POS_W-1:0];
                dspd_pkg::REG_START_C:       start_c_reg   <= cfg_data[dspd_pkg::POS_W-1:0];
                dspd_pkg::REG_BASE_STEERING: base_reg      <= cfg_data[dspd_pkg::BASE_W-1:0];
                dspd_pkg::REG_B_IS_MAIN:     b_is_main_reg <= cfg_data[0];
                dspd_pkg::REG_GAIN_P:        gain_p_reg    <= cfg_data[dspd_pkg::GAIN_W-1:0];
                dspd_pkg::REG_GAIN_D:        gain_d_reg    <= cfg_data[dspd_pkg::GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.target_b      = target_b_reg;
    assign cfg.target_c      = target_c_reg;
    assign cfg.start_b       = start_b_reg;
    assign cfg.start_c       = start_c_reg;
    assign cfg.base_steering = base_reg;
    assign cfg.b_is_main     = b_is_main_reg;
    assign cfg.gain_p        = gain_p_reg;
    assign cfg.gain_d        = gain_d_reg;

    dspd_front u_front (
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .position_b (position_b),
        .position_c (position_c),
        .speed_in   (speed_in),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    dspd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    dspd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_empty      (q_empty),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .steering_out (steering_out),
        .speed_out    (speed_out)
    );

endmodule

[hw/rtl/dspd_checker.sv]
// ----------------------------------------------------------------------------
// dspd_checker
// port level checks on the steering correction core
// ----------------------------------------------------------------------------
`include "differential_steering_pd_sync_core_assert.svh"

module dspd_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic signed [dspd_pkg::STEER_W-1:0]     steering_out,
    input  logic signed [dspd_pkg::SPEED_W-1:0]     speed_out,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready
);

    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       in_take;
    logic       out_take;
    logic       steer_ok;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;
    assign steer_ok = (steering_out >= -dspd_pkg::FOLD_LIMIT)
                   && (steering_out <= dspd_pkg::FOLD_LIMIT);

    always_comb
    begin
        pending_next = pending_reg;
        if (in_take && !out_take)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_take && !in_take)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // stalled result holds
    `DSPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(steering_out) && $stable(speed_out))

    // folded steering stays in range
    `DSPD_ASSERT_NOW(a_steer_range, clk, rst_n, out_valid, steer_ok)

    // no result without an accepted transaction behind it
    `DSPD_ASSERT_NOW(a_no_phantom, clk, rst_n, out_valid, pending_reg != 4'd0)

    // config port never back-pressures
    `DSPD_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind differential_steering_pd_sync_core dspd_checker u_checker (.*);

[tb/differential_steering_pd_sync_core_tb.sv]
// ----------------------------------------------------------------------------
// differential_steering_pd_sync_core_tb
// drives wheel position samples through the steering correction core under
// random idle and stall, predicts each pd correction with its own copy of the
// registers and the previous error, and checks steering and speed per result
// ----------------------------------------------------------------------------
module differential_steering_pd_sync_core_tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PCT      = 30;
    localparam int DRAIN_CYCLES  = 24;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_SAMPLES = 80;

    typedef struct {
        logic signed [dspd_pkg::STEER_W-1:0] steering;
        logic signed [dspd_pkg::SPEED_W-1:0] speed;
    } correction_t;

    class steering_scoreboard;
        logic signed [dspd_pkg::POS_W-1:0]  target_b;
        logic signed [dspd_pkg::POS_W-1:0]  target_c;
        logic signed [dspd_pkg::POS_W-1:0]  start_b;
        logic signed [dspd_pkg::POS_W-1:0]  start_c;
        logic signed [dspd_pkg::BASE_W-1:0] base_steering;
        logic                               b_is_main;
        logic [dspd_pkg::GAIN_W-1:0]        gain_p;
        logic [dspd_pkg::GAIN_W-1:0]        gain_d;
        longint                             prev_err;
        correction_t                        expected_corrections[$];
        int                                 errors;
        int                                 samples;
        int                                 results;

        function new();
            target_b      = '0;
            target_c      = '0;
            start_b       = '0;
            start_c       = '0;
            base_steering = '0;
            b_is_main     = 1'b1;
            gain_p        = 16'd256;
            gain_d        = '0;
            prev_err      = 0;
            errors        = 0;
            samples       = 0;
            results       = 0;
        endfunction

        function void write_reg(logic [dspd_pkg::CFG_IDX_W-1:0] idx,
                                logic [dspd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                dspd_pkg::REG_TARGET_B:      target_b = data[dspd_pkg::POS_W-1:0];
                dspd_pkg::REG_TARGET_C:      target_c = data[dspd_pkg::POS_W-1:0];
                dspd_pkg::REG_START_B:       start_b = data[dspd_pkg::POS_W-1:0];
                dspd_pkg::REG_START_C:       start_c = data[dspd_pkg::POS_W-1:0];
                dspd_pkg::REG_BASE_STEERING: base_steering = data[dspd_pkg::BASE_W-1:0];
                dspd_pkg::REG_B_IS_MAIN:     b_is_main = data[0];
                dspd_pkg::REG_GAIN_P:        gain_p = data[dspd_pkg::GAIN_W-1:0];
                dspd_pkg::REG_GAIN_D:        gain_d = data[dspd_pkg::GAIN_W-1:0];
                default:                     ;
            endcase
        endfunction

        // pd correction of one position sample, in transaction order
        function void take_sample(logic signed [dspd_pkg::POS_W-1:0] pos_b,
                                  logic signed [dspd_pkg::POS_W-1:0] pos_c,
                                  logic signed [dspd_pkg::SPEED_W-1:0] spd);
            longint      one;
            longint      base;
            longint      left_b;
            longint      left_c;
            longint      err;
            longint      pd;
            longint      sum;
            correction_t exp_c;
            one    = longint'(1) << dspd_pkg::FRAC_BITS;
            base   = longint'(base_steering);
            left_b = longint'(target_b) - longint'(pos_b) + longint'(start_b);
            left_c = longint'(target_c) - longint'(pos_c) + longint'(start_c);
            if (b_is_main)
                err = (left_b * (dspd_pkg::STEER_SCALE - base)) / dspd_pkg::STEER_SCALE
                      - left_c;
            else
                err = left_b
                      - (left_c * (dspd_pkg::STEER_SCALE + base)) / dspd_pkg::STEER_SCALE;
            pd = err * longint'(gain_p) + (err - prev_err) * longint'(gain_d);
            if (longint'(spd) > 0)
                sum = (base * one + pd) / one;
            else
                sum = (base * one - pd) / one;
            if (sum > dspd_pkg::SAT_LIMIT)
                sum = dspd_pkg::SAT_LIMIT;
            else if (sum < -dspd_pkg::SAT_LIMIT)
                sum = -dspd_pkg::SAT_LIMIT;
            exp_c.speed = spd;
            if (sum > dspd_pkg::FOLD_LIMIT)
            begin
                sum -= dspd_pkg::FOLD_STEP;
                exp_c.speed = -spd;
            end
            else if (sum < -dspd_pkg::FOLD_LIMIT)
            begin
                sum += dspd_pkg::FOLD_STEP;
                exp_c.speed = -spd;
            end
            exp_c.steering = sum[dspd_pkg::STEER_W-1:0];
            prev_err = err;
            samples++;
            expected_corrections.push_back(exp_c);
        endfunction

        function void check_correction(logic signed [dspd_pkg::STEER_W-1:0] steer,
                                       logic signed [dspd_pkg::SPEED_W-1:0] spd);
            correction_t exp_c;
            results++;
            if (expected_corrections.size() == 0)
            begin
                $error("unexpected result transaction: steering_out %0d, speed_out %0d",
                       steer, spd);
                errors++;
                return;
            end
            exp_c = expected_corrections.pop_front();
            if (steer !== exp_c.steering)
            begin
                $error("steering_out mismatch: expected %0d, actual %0d", exp_c.steering, steer);
                errors++;
            end
            if (spd !== exp_c.speed)
            begin
                $error("speed_out mismatch: expected %0d, actual %0d", exp_c.speed, spd);
                errors++;
            end
        endfunction

        function int pending();
            return expected_corrections.size();
        endfunction
    endclass

    logic                                   clk;
    logic                                   rst_n      = 1'b0;
    logic                                   in_valid   = 1'b0;
    logic                                   in_stall;
    logic signed [dspd_pkg::POS_W-1:0]      position_b = '0;
    logic signed [dspd_pkg::POS_W-1:0]      position_c = '0;
    logic signed [dspd_pkg::SPEED_W-1:0]    speed_in   = '0;
    logic                                   out_valid;
    logic                                   out_stall  = 1'b0;
    logic signed [dspd_pkg::STEER_W-1:0]    steering_out;
    logic signed [dspd_pkg::SPEED_W-1:0]    speed_out;
    logic                                   cfg_valid  = 1'b0;
    logic                                   cfg_ready;
    logic [dspd_pkg::CFG_IDX_W-1:0]         cfg_index  = '0;
    logic [dspd_pkg::CFG_DATA_W-1:0]        cfg_data   = '0;

    steering_scoreboard board = new();
    bit quiet = 1'b0;
    int cycles = 0;
    int settings_loaded = 1;
    int phase_target_b;
    int phase_target_c;
    int phase_start_b;
    int phase_start_c;

    differential_steering_pd_sync_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .position_b   (position_b),
        .position_c   (position_c),
        .speed_in     (speed_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .steering_out (steering_out),
        .speed_out    (speed_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.take_sample(position_b, position_c, speed_in);
            if (out_valid && !out_stall)
                board.check_correction(steering_out, speed_out);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("differential_steering_pd_sync_core_tb: done, errors");
            $finish;
        end
    end

    task automatic send_sample(input int pos_b, input int pos_c, input int spd);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        position_b <= dspd_pkg::POS_W'(pos_b);
        position_c <= dspd_pkg::POS_W'(pos_c);
        speed_in   <= dspd_pkg::SPEED_W'(spd);
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(input logic [dspd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dspd_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, data);
    endtask

    // unused upper bits of the narrow registers carry random junk
    task automatic load_settings(input int tb, input int tc, input int sb, input int sc,
                                 input int base, input int bmain, input int gp, input int gd);
        write_reg(dspd_pkg::REG_TARGET_B, dspd_pkg::CFG_DATA_W'(tb));
        write_reg(dspd_pkg::REG_TARGET_C, dspd_pkg::CFG_DATA_W'(tc));
        write_reg(dspd_pkg::REG_START_B, dspd_pkg::CFG_DATA_W'(sb));
        write_reg(dspd_pkg::REG_START_C, dspd_pkg::CFG_DATA_W'(sc));
        write_reg(dspd_pkg::REG_BASE_STEERING, {16'($urandom()), dspd_pkg::BASE_W'(base)});
        write_reg(dspd_pkg::REG_B_IS_MAIN, {23'($urandom()), 1'(bmain)});
        write_reg(dspd_pkg::REG_GAIN_P, {8'($urandom()), dspd_pkg::GAIN_W'(gp)});
        write_reg(dspd_pkg::REG_GAIN_D, {8'($urandom()), dspd_pkg::GAIN_W'(gd)});
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // the first wait lets the last accepted sample be counted before polling
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // targets roughly matched to the steering ratio so the error stays small
    task automatic random_settings();
        int base;
        int bmain;
        int tm;
        int tb;
        int tc;
        int gp;
        int gd;
        base  = ($urandom_range(0, 9) == 0) ? int'($signed(8'($urandom())))
                                            : int'($urandom_range(0, 200)) - 100;
        bmain = int'($urandom_range(0, 1));
        tm    = int'($urandom_range(0, 40000)) - 20000;
        if (bmain != 0)
        begin
            tb = tm;
            tc = tm * (dspd_pkg::STEER_SCALE - base) / dspd_pkg::STEER_SCALE
                 + int'($urandom_range(0, 10)) - 5;
        end
        else
        begin
            tc = tm;
            tb = tm * (dspd_pkg::STEER_SCALE + base) / dspd_pkg::STEER_SCALE
                 + int'($urandom_range(0, 10)) - 5;
        end
        if ($urandom_range(0, 4) == 0)
        begin
            tb = int'($signed(24'($urandom())));
            tc = int'($signed(24'($urandom())));
        end
        gp = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 1024)) : int'(16'($urandom()));
        gd = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 512)) : int'(16'($urandom()));
        phase_target_b = tb;
        phase_target_c = tc;
        phase_start_b  = int'($signed(24'($urandom())));
        phase_start_c  = int'($signed(24'($urandom())));
        load_settings(tb, tc, phase_start_b, phase_start_c, base, bmain, gp, gd);
    endtask

    // mostly wheels that follow their targets, some arbitrary encoder noise
    task automatic random_sample();
        int     k;
        int     spd;
        longint pb;
        longint pc;
        spd = ($urandom_range(0, 99) < 85) ? int'($urandom_range(0, 200)) - 100
                                           : int'($signed(8'($urandom())));
        if ($urandom_range(0, 99) < 80)
        begin
            k  = int'($urandom_range(0, 1000));
            pb = longint'(phase_start_b) + longint'(phase_target_b) * k / 1000
                 + longint'($urandom_range(0, 32)) - 16;
            pc = longint'(phase_start_c) + longint'(phase_target_c) * k / 1000
                 + longint'($urandom_range(0, 32)) - 16;
        end
        else
        begin
            pb = longint'($urandom());
            pc = longint'($urandom());
        end
        send_sample(int'(pb), int'(pc), spd);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unit p gain, error is position_c - position_b
        send_sample(0, 0, 0);
        send_sample(0, 50, 10);
        send_sample(0, 100, 10);
        send_sample(0, 101, 10);
        send_sample(0, -101, 10);
        send_sample(0, 150, 0);
        send_sample(0, 500, 1);
        send_sample(0, -500, -128);
        send_sample(0, 300, -128);
        send_sample(-8388608, 8388607, 127);
        send_sample(8388607, -8388608, -100);
        send_sample(-1, -1, 100);
        send_sample(8388607, 8388607, -1);
        send_sample(5, -3, 127);

        // wheel c as reference, base below range, fractional gains
        wait_idle();
        load_settings(8388607, -8388608, -8388608, 8388607, -128, 0, 'h0180, 'h00c0);
        send_sample(0, 0, 5);
        send_sample(-8388608, 8388607, -5);
        send_sample(8388607, -8388608, 100);
        send_sample(3, 7, -100);
        send_sample(0, 2, 1);

        // wheel b as reference, base above range, full gains
        wait_idle();
        load_settings(-8388608, 8388607, 8388607, -8388608, 127, 1, 'hffff, 'hffff);
        send_sample(0, 0, 1);
        send_sample(8388607, -8388608, -128);
        send_sample(-8388608, 8388607, 127);
        send_sample(-1, 1, 0);
        send_sample(1, 0, -1);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            random_settings();
            quiet = (p == 3);
            for (int i = 0; i < PHASE_SAMPLES; i++)
                random_sample();
        end
        quiet = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("checked %0d corrections from %0d position samples", board.results,
                 board.samples);
        $display("register settings used: %0d, including full-scale and out-of-range ones",
                 settings_loaded);
        if (board.errors == 0 && board.pending() == 0)
            $display("differential_steering_pd_sync_core_tb: done, clean");
        else
            $display("differential_steering_pd_sync_core_tb: done, errors");
        $finish;
    end

endmodule
